FILE: rtl/egs_pkg.sv
// shared types, constants and cell-rule functions for the epidemic grid generation step
`default_nettype none

package egs_pkg;

    // grid limits and derived widths
    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int COLS_W   = $clog2(MAX_COLS + 1);
    localparam int ROW_W    = $clog2(MAX_ROWS + 1);

    // fixed field widths
    localparam int CODE_W     = 3;
    localparam int DRAW_W     = 14;
    localparam int CNT_W      = 21;
    localparam int SIZE_W     = 11;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // cell codes
    localparam logic [CODE_W-1:0] CODE_EMPTY        = 3'd0;
    localparam logic [CODE_W-1:0] CODE_HEALTHY      = 3'd1;
    localparam logic [CODE_W-1:0] CODE_CONTAMINATED = 3'd2;
    localparam logic [CODE_W-1:0] CODE_DEAD         = 3'd3;
    localparam logic [CODE_W-1:0] CODE_DEAD_PREV    = 3'd4;

    // register reset values
    localparam logic [SIZE_W-1:0] RST_GRID_ROWS     = 11'd1;
    localparam logic [SIZE_W-1:0] RST_GRID_COLS     = 11'd1;
    localparam logic [DRAW_W-1:0] RST_RECOVER_LIMIT = 14'd1000;
    localparam logic [DRAW_W-1:0] RST_STAY_LIMIT    = 14'd4000;

    // register map, one word each
    typedef enum logic [1:0] {
        REG_GRID_ROWS,
        REG_GRID_COLS,
        REG_RECOVER_LIMIT,
        REG_STAY_LIMIT
    } reg_index_t;

    // input beat
    typedef struct packed {
        logic [CODE_W-1:0] cell_code;
        logic [DRAW_W-1:0] random_draw;
        logic              pad_item;
    } cell_beat_t;

    // result beat
    typedef struct packed {
        logic [CODE_W-1:0] next_code;
        logic              last_cell;
        logic [CNT_W-1:0]  healthy_total;
        logic [CNT_W-1:0]  infected_total;
        logic [CNT_W-1:0]  dead_total;
        logic              still_spreading;
    } result_beat_t;

    // one entry of the center line buffer
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [DRAW_W-1:0] draw;
    } center_entry_t;

    // line buffer write request
    typedef struct packed {
        logic              en;
        logic [COL_W-1:0]  col;
        logic [CODE_W-1:0] above_code;
        center_entry_t     center;
    } lb_wr_t;

    // neighbor that can pass contamination on
    function automatic logic spreads(input logic [CODE_W-1:0] code);
        return (code == CODE_CONTAMINATED) || (code == CODE_DEAD) || (code == CODE_DEAD_PREV);
    endfunction

    // cell transition rule
    function automatic logic [CODE_W-1:0] next_code_of(
        input logic [CODE_W-1:0] code,
        input logic [DRAW_W-1:0] draw,
        input logic              exposed,
        input logic [DRAW_W-1:0] recover_limit,
        input logic [DRAW_W-1:0] stay_limit
    );
        logic [CODE_W-1:0] nxt;
        nxt = CODE_EMPTY;
        case (code)
            CODE_HEALTHY:      nxt = exposed ? CODE_CONTAMINATED : CODE_HEALTHY;
            CODE_CONTAMINATED:
            begin
                if (draw < recover_limit)
                    nxt = CODE_HEALTHY;
                else if (draw < stay_limit)
                    nxt = CODE_CONTAMINATED;
                else
                    nxt = CODE_DEAD;
            end
            CODE_DEAD:         nxt = CODE_DEAD_PREV;
            default:           nxt = CODE_EMPTY;
        endcase
        return nxt;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/egs_line_buf.sv
// two line buffers with registered reads, write forwarding and a clearing pass after reset
`default_nettype none

module egs_line_buf (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    output logic                             busy,
    input  wire logic                        rd_en,
    input  wire logic [egs_pkg::COL_W-1:0]   rd_col,
    input  wire egs_pkg::lb_wr_t             wr,
    output logic [egs_pkg::CODE_W-1:0]       above_code,
    output egs_pkg::center_entry_t           center_here,
    output egs_pkg::center_entry_t           center_right
);

    logic [egs_pkg::CODE_W-1:0]  above_mem [egs_pkg::MAX_COLS];
    egs_pkg::center_entry_t      center_mem [egs_pkg::MAX_COLS];

    logic [egs_pkg::COLS_W-1:0]  clr_cnt_reg;
    logic                        clearing;
    logic [egs_pkg::COL_W-1:0]   wr_addr;
    logic                        wr_en;
    logic [egs_pkg::CODE_W-1:0]  wr_above;
    egs_pkg::center_entry_t      wr_center;
    logic [egs_pkg::COL_W-1:0]   right_col;

    logic [egs_pkg::CODE_W-1:0]  above_rd_reg;
    egs_pkg::center_entry_t      here_rd_reg;
    egs_pkg::center_entry_t      right_rd_reg;
    logic                        fwd_here_reg;
    logic                        fwd_right_reg;
    logic [egs_pkg::CODE_W-1:0]  fwd_above_data_reg;
    egs_pkg::center_entry_t      fwd_here_data_reg;
    egs_pkg::center_entry_t      fwd_right_data_reg;

    // clearing pass, one entry per cycle
    assign clearing = 32'(clr_cnt_reg) < 32'(egs_pkg::MAX_COLS);
    assign busy     = clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (clearing)
            clr_cnt_reg <= egs_pkg::COLS_W'(32'(clr_cnt_reg) + 32'd1);
    end

    // write port select
    assign wr_en     = clearing || wr.en;
    assign wr_addr   = clearing ? clr_cnt_reg[egs_pkg::COL_W-1:0] : wr.col;
    assign wr_above  = clearing ? egs_pkg::CODE_EMPTY : wr.above_code;
    assign wr_center = clearing ? '0 : wr.center;

    // right neighbor address, wrapped at the buffer end
    assign right_col = (32'(rd_col) == 32'(egs_pkg::MAX_COLS - 1)) ? '0
                     : egs_pkg::COL_W'(32'(rd_col) + 32'd1);

    // memories
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            above_mem[wr_addr]  <= wr_above;
            center_mem[wr_addr] <= wr_center;
        end
        if (rd_en)
        begin
            above_rd_reg <= above_mem[rd_col];
            here_rd_reg  <= center_mem[rd_col];
            right_rd_reg <= center_mem[right_col];
        end
    end

    // forwarding of a write that lands on the same edge as the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_here_reg  <= 1'b0;
            fwd_right_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_here_reg  <= wr.en && (wr.col == rd_col);
            fwd_right_reg <= wr.en && (wr.col == right_col);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_above_data_reg <= wr.above_code;
            fwd_here_data_reg  <= wr.center;
            fwd_right_data_reg <= wr.center;
        end
    end

    assign above_code   = fwd_here_reg  ? fwd_above_data_reg : above_rd_reg;
    assign center_here  = fwd_here_reg  ? fwd_here_data_reg  : here_rd_reg;
    assign center_right = fwd_right_reg ? fwd_right_data_reg : right_rd_reg;

endmodule

`default_nettype wire

FILE: rtl/epidemic_grid_generation_step.sv
// top level of the epidemic grid generation step: registers, raster control and stencil
//
// Usage: the host streams one generation in raster order on the cell channel, one beat
// per cell, then one row of grid_cols pad beats to flush the last row. Each beat after
// the first grid row yields one result beat with the next code of the cell one row
// above; the result of the final cell carries last_cell and the population totals.
// Beats move on valid high and stall low; cell_stall is driven by this block and
// result_stall by the receiver.
// Path: a cell beat is taken into the input register while the line buffers are read into
// their read registers; the stencil result then enters the result register when the input
// register advances, which waits while a stalled result is held.
// Throughput: one beat per cycle when no stall holds it, set by the single write port of
// each line buffer and the two read ports of the center buffer, which are used once per beat.
// Reset: registers return to rows 1, cols 1, limits 1000 and 4000; the line buffers are
// then cleared one entry per cycle, all 1024 entries, during which cell_stall is high.
// Stall: while result_stall holds a result, one more result-producing cell beat is taken
// into the input register and then cell_stall rises until the result register frees up.
// Registers must be written over APB only while the block is idle; the block does not enforce it.
`default_nettype none

module epidemic_grid_generation_step (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cell_valid,
    output logic                                 cell_stall,
    input  wire egs_pkg::cell_beat_t             cell_data,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output egs_pkg::result_beat_t                result,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [egs_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [egs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [egs_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    // configuration registers
    logic [egs_pkg::SIZE_W-1:0] grid_rows_reg;
    logic [egs_pkg::SIZE_W-1:0] grid_cols_reg;
    logic [egs_pkg::DRAW_W-1:0] recover_limit_reg;
    logic [egs_pkg::DRAW_W-1:0] stay_limit_reg;
    egs_pkg::reg_index_t        reg_sel;
    logic                       cfg_write;

    // raster position and clamped sizes
    logic [egs_pkg::ROW_W-1:0]  row_reg;
    logic [egs_pkg::COL_W-1:0]  col_reg;
    logic [egs_pkg::ROW_W-1:0]  rows;
    logic [egs_pkg::COLS_W-1:0] cols;
    logic [egs_pkg::ROW_W-1:0]  cur_row;
    logic [egs_pkg::COL_W-1:0]  cur_col;
    logic                       cur_flush;
    logic                       cur_row_end;
    logic                       cur_last;
    logic [egs_pkg::ROW_W-1:0]  row_next;
    logic [egs_pkg::COL_W-1:0]  col_next;

    // input register stage
    logic                       s1_valid_reg;
    logic [egs_pkg::COL_W-1:0]  s1_col_reg;
    egs_pkg::center_entry_t     s1_in_reg;
    logic                       s1_produce_reg;
    logic                       s1_use_above_reg;
    logic                       s1_use_left_reg;
    logic                       s1_use_right_reg;
    logic                       s1_last_reg;
    egs_pkg::center_entry_t     in_entry;

    // handshake
    logic                       cell_accept;
    logic                       s1_advance;
    logic                       out_free;
    logic                       lb_busy;

    // line buffer connection
    egs_pkg::lb_wr_t            lb_wr;
    logic [egs_pkg::CODE_W-1:0] above_code;
    egs_pkg::center_entry_t     center_here;
    egs_pkg::center_entry_t     center_right;
    logic [egs_pkg::CODE_W-1:0] left_code_reg;

    // stencil and counters
    logic                       exposed;
    logic [egs_pkg::CODE_W-1:0] nxt_code;
    logic [egs_pkg::CNT_W-1:0]  healthy_reg;
    logic [egs_pkg::CNT_W-1:0]  infected_reg;
    logic [egs_pkg::CNT_W-1:0]  dead_reg;
    logic [egs_pkg::CNT_W-1:0]  healthy_next;
    logic [egs_pkg::CNT_W-1:0]  infected_next;
    logic [egs_pkg::CNT_W-1:0]  dead_next;

    logic                       result_valid_reg;
    egs_pkg::result_beat_t      result_reg;
    egs_pkg::result_beat_t      result_next;

    // apb register file
    assign pready    = 1'b1;
    assign reg_sel   = egs_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg     <= egs_pkg::RST_GRID_ROWS;
            grid_cols_reg     <= egs_pkg::RST_GRID_COLS;
            recover_limit_reg <= egs_pkg::RST_RECOVER_LIMIT;
            stay_limit_reg    <= egs_pkg::RST_STAY_LIMIT;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                egs_pkg::REG_GRID_ROWS:     grid_rows_reg     <= pwdata[egs_pkg::SIZE_W-1:0];
                egs_pkg::REG_GRID_COLS:     grid_cols_reg     <= pwdata[egs_pkg::SIZE_W-1:0];
                egs_pkg::REG_RECOVER_LIMIT: recover_limit_reg <= pwdata[egs_pkg::DRAW_W-1:0];
                egs_pkg::REG_STAY_LIMIT:    stay_limit_reg    <= pwdata[egs_pkg::DRAW_W-1:0];
                default:                    ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            egs_pkg::REG_GRID_ROWS:     prdata = egs_pkg::APB_DATA_W'(grid_rows_reg);
            egs_pkg::REG_GRID_COLS:     prdata = egs_pkg::APB_DATA_W'(grid_cols_reg);
            egs_pkg::REG_RECOVER_LIMIT: prdata = egs_pkg::APB_DATA_W'(recover_limit_reg);
            egs_pkg::REG_STAY_LIMIT:    prdata = egs_pkg::APB_DATA_W'(stay_limit_reg);
            default:                    prdata = '0;
        endcase
    end

    // clamp sizes to 1..max
    always_comb
    begin
        if (grid_rows_reg == '0)
            rows = egs_pkg::ROW_W'(1);
        else if (32'(grid_rows_reg) > 32'(egs_pkg::MAX_ROWS))
            rows = egs_pkg::ROW_W'(egs_pkg::MAX_ROWS);
        else
            rows = egs_pkg::ROW_W'(grid_rows_reg);

        if (grid_cols_reg == '0)
            cols = egs_pkg::COLS_W'(1);
        else if (32'(grid_cols_reg) > 32'(egs_pkg::MAX_COLS))
            cols = egs_pkg::COLS_W'(egs_pkg::MAX_COLS);
        else
            cols = egs_pkg::COLS_W'(grid_cols_reg);
    end

    // position of the beat at the input and the one after it
    always_comb
    begin
        cur_col     = (32'(col_reg) >= 32'(cols)) ? '0 : col_reg;
        cur_row     = (32'(row_reg) > 32'(rows)) ? rows : row_reg;
        cur_flush   = 32'(cur_row) >= 32'(rows);
        cur_row_end = (32'(cur_col) + 32'd1) >= 32'(cols);
        cur_last    = cur_flush && cur_row_end;

        if (cur_last)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (cur_row_end)
        begin
            row_next = egs_pkg::ROW_W'(32'(cur_row) + 32'd1);
            col_next = '0;
        end
        else
        begin
            row_next = cur_row;
            col_next = egs_pkg::COL_W'(32'(cur_col) + 32'd1);
        end
    end

    // cell fields after flush and pad handling
    always_comb
    begin
        in_entry.code = cell_data.cell_code;
        in_entry.draw = cell_data.random_draw;
        if (cur_flush)
        begin
            in_entry.code = egs_pkg::CODE_EMPTY;
            in_entry.draw = '0;
        end
        else if (cell_data.pad_item)
            in_entry.code = egs_pkg::CODE_EMPTY;
    end

    // handshake
    assign out_free    = !result_valid_reg || !result_stall;
    assign s1_advance  = s1_valid_reg && (!s1_produce_reg || out_free);
    assign cell_stall  = lb_busy || (s1_valid_reg && !s1_advance);
    assign cell_accept = cell_valid && !cell_stall;

    // position registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cell_accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // input register stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (cell_accept)
            s1_valid_reg <= 1'b1;
        else if (s1_advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cell_accept)
        begin
            s1_col_reg       <= cur_col;
            s1_in_reg        <= in_entry;
            s1_produce_reg   <= cur_row != '0;
            s1_use_above_reg <= 32'(cur_row) >= 32'd2;
            s1_use_left_reg  <= cur_col != '0;
            s1_use_right_reg <= !cur_row_end;
            s1_last_reg      <= cur_last;
        end
    end

    // line buffers
    assign lb_wr.en         = s1_advance;
    assign lb_wr.col        = s1_col_reg;
    assign lb_wr.above_code = center_here.code;
    assign lb_wr.center     = s1_in_reg;

    egs_line_buf u_line_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .busy         (lb_busy),
        .rd_en        (cell_accept),
        .rd_col       (cur_col),
        .wr           (lb_wr),
        .above_code   (above_code),
        .center_here  (center_here),
        .center_right (center_right)
    );

    // left neighbor above: the center code the previous beat moved up
    always_ff @(posedge clk)
    begin
        if (s1_advance)
            left_code_reg <= center_here.code;
    end

    // stencil
    always_comb
    begin
        exposed = (s1_use_above_reg && egs_pkg::spreads(above_code))
               || egs_pkg::spreads(s1_in_reg.code)
               || (s1_use_left_reg && egs_pkg::spreads(left_code_reg))
               || (s1_use_right_reg && egs_pkg::spreads(center_right.code));
        nxt_code = egs_pkg::next_code_of(center_here.code, center_here.draw, exposed,
                                         recover_limit_reg, stay_limit_reg);
    end

    // saturating population counts
    always_comb
    begin
        healthy_next  = healthy_reg;
        infected_next = infected_reg;
        dead_next     = dead_reg;
        case (nxt_code) inside
            egs_pkg::CODE_HEALTHY:
                if (healthy_reg != egs_pkg::CNT_MAX)
                    healthy_next = healthy_reg + 1'b1;
            egs_pkg::CODE_CONTAMINATED:
                if (infected_reg != egs_pkg::CNT_MAX)
                    infected_next = infected_reg + 1'b1;
            egs_pkg::CODE_DEAD, egs_pkg::CODE_DEAD_PREV:
                if (dead_reg != egs_pkg::CNT_MAX)
                    dead_next = dead_reg + 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            healthy_reg  <= '0;
            infected_reg <= '0;
            dead_reg     <= '0;
        end
        else if (s1_advance && s1_produce_reg)
        begin
            if (s1_last_reg)
            begin
                healthy_reg  <= '0;
                infected_reg <= '0;
                dead_reg     <= '0;
            end
            else
            begin
                healthy_reg  <= healthy_next;
                infected_reg <= infected_next;
                dead_reg     <= dead_next;
            end
        end
    end

    // result beat
    always_comb
    begin
        result_next.next_code       = nxt_code;
        result_next.last_cell       = s1_last_reg;
        result_next.healthy_total   = s1_last_reg ? healthy_next  : '0;
        result_next.infected_total  = s1_last_reg ? infected_next : '0;
        result_next.dead_total      = s1_last_reg ? dead_next     : '0;
        result_next.still_spreading = s1_last_reg && (infected_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (s1_advance && s1_produce_reg)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_produce_reg)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

FILE: rtl/egs_checker.sv
// port-level checker for the epidemic grid generation step and its bind
`default_nettype none

module egs_checker (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  cell_stall,
    input wire logic                  result_valid,
    input wire logic                  result_stall,
    input wire egs_pkg::result_beat_t result
);

    // stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

    // totals only ride on the final cell
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_cell |->
            result.healthy_total == '0 && result.infected_total == '0 &&
            result.dead_total == '0 && !result.still_spreading)
    else $error("totals on a beat that is not the final cell");

    // spreading flag follows the contaminated total
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_cell |->
            result.still_spreading == (result.infected_total != '0))
    else $error("still_spreading disagrees with infected_total");

    // input is held off as reset releases, when the line buffer clearing pass starts
    assert property (@(posedge clk)
        $rose(rst_n) |-> cell_stall)
    else $error("cell beat possible during clearing pass");

    // next code stays within the defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.next_code <= egs_pkg::CODE_DEAD_PREV)
    else $error("undefined next code");

endmodule

bind epidemic_grid_generation_step egs_checker u_egs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cell_stall   (cell_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
